// ===== rtl/rdft_pkg.sv =====
// Shared types and constants for the ranging distance filter table.
// Used by rdft_mul and ranging_distance_filter_table_core.
package rdft_pkg;

  localparam int LINKS_DEF  = 16;
  localparam int WINDOW_DEF = 5;

  // shared multiplier: signed difference times unsigned weight
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 10;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_TOO_FAR  = 3'd1;
  localparam logic [2:0] ST_OUTLIER  = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  localparam logic [2:0] CFG_MAX_ACCEPT = 3'd0;
  localparam logic [2:0] CFG_MIN_VALID  = 3'd1;
  localparam logic [2:0] CFG_MAX_VALID  = 3'd2;
  localparam logic [2:0] CFG_OUTLIER    = 3'd3;
  localparam logic [2:0] CFG_WEIGHT     = 3'd4;
  localparam logic [2:0] CFG_LONG_RANGE = 3'd5;

  localparam logic signed [15:0] RSSI_RESET_Q8 = -16'sd25600;
  localparam logic signed [15:0] RSSI_SEED_Q8  = -16'sd25344;

  typedef struct packed {
    logic               lr;
    logic signed [15:0] rssi;
    logic [23:0]        smooth;
    logic [15:0]        median;
    logic [2:0]         fill;
    logic [2:0]         ptr;
  } slot_rec_t;

  localparam slot_rec_t REC_RESET = '{lr: 1'b0, rssi: RSSI_RESET_Q8, smooth: 24'd0,
                                      median: 16'd0, fill: 3'd0, ptr: 3'd0};

endpackage

// ===== rtl/rdft_mul.sv =====
// Shared registered multiplier for both EMA updates.
// Depends on rdft_pkg for operand widths.
module rdft_mul
  import rdft_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ===== rtl/ranging_distance_filter_table_core.sv =====
// Top level of the ranging distance filter table: slot store, window store,
// sequencer and median rank unit. Depends on rdft_pkg and rdft_mul.
//
// Usage:
//   in_*  : one beat per request. in_tuser is the op (0 measure, 1 clear slot).
//   out_* : one result beat per request, held until out_tready.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Flow: in_tready is high only while the sequencer is idle. A clear or a
// too-far distance goes from the slot read and evaluation straight to
// write-back; an outlier or out-of-range distance also passes the RSSI update.
// An accepted distance then reads the window memory once per entry held after
// the new one (up to WINDOW), makes one rank compare per window position
// through the shared compare logic, then takes the median and smooths it before
// write-back. in_tready rises with out_tvalid, so no next beat is taken before
// the result beat is valid. Both EMAs use the one shared multiplier.
// A stalled receiver holds the result beat; the block then waits before
// returning to idle. Reset (rst_n low, synchronous) clears the slot valid
// bits, so every slot reads as empty; no clearing pass is needed, and the
// registers return to their default values.
module ranging_distance_filter_table_core
  import rdft_pkg::*;
#(
  parameter int LINKS  = LINKS_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // link_index[3:0], dist_cm[19:4], rssi_dbm[27:20]
  input  logic [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // median[15:0], smoothed[31:16], rssi_mean[39:32],
                                  // far[40]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int WA = LINKS * WINDOW;
  localparam int AW = (WA > 1) ? $clog2(WA) : 1;
  localparam int XW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_EVAL, S_RSSI, S_WRD, S_WCAP, S_RANK, S_MED, S_SMOOTH, S_WB, S_DONE
  } state_t;

  state_t      state_r;
  logic        op_r;
  logic [SW-1:0] slot_r;
  logic [15:0] dist_r;
  logic signed [7:0] rssi_r;
  slot_rec_t   rec_r;
  logic [2:0]  status_r;
  logic        seed_r;
  logic [XW-1:0] idx_r;
  logic [XW-1:0] p_r;
  logic [15:0] win_r [WINDOW];
  logic [15:0] lo_r, hi_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic [2:0]  out_user_r;

  logic [15:0] max_acc_r, min_val_r, max_val_r, outl_r, lr_thr_r;
  logic [8:0]  weight_r;
  logic [8:0]  w;

  logic [LINKS-1:0] slot_vld_r;
  slot_rec_t   slot_mem [LINKS];
  slot_rec_t   rec_rd_r;
  logic        rec_vld_r;
  logic [15:0] win_mem [WA];
  logic [15:0] win_rd_r;

  logic [SW-1:0] in_slot;
  slot_rec_t   cur_rec;
  logic [AW-1:0] win_base, win_raddr, win_waddr;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [MUL_P_W-1:0] mul_sh;
  logic [15:0] rssi_upd;
  logic [23:0] smooth_upd;
  logic [15:0] diff;
  logic        outlier, dist_ok;
  logic [WINDOW-1:0] vm;
  logic [2:0]  cnt, rank, lo_rank, hi_rank;
  logic [15:0] med;
  logic [2:0]  fill_nxt, ptr_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign w = (weight_r > 9'd256) ? 9'd256 : weight_r;

  always_comb begin
    in_slot = '0;
    for (int k = 0; k < 16; k++) begin
      if (in_tdata[3:0] == 4'(k)) in_slot = SW'(k % LINKS);
    end
  end

  assign cur_rec   = rec_vld_r ? rec_rd_r : REC_RESET;
  assign win_base  = AW'(slot_r) * AW'(WINDOW);
  assign win_raddr = win_base + AW'(idx_r);
  assign win_waddr = win_base + AW'(p_r);

  // outlier and window-entry tests on the working record
  assign diff    = (dist_r > rec_r.median) ? dist_r - rec_r.median : rec_r.median - dist_r;
  assign outlier = (rec_r.median != 16'd0) && (diff > outl_r);
  assign dist_ok = (dist_r >= min_val_r) && (dist_r <= max_val_r);
  assign fill_nxt = (rec_r.fill < 3'(WINDOW)) ? rec_r.fill + 3'd1 : rec_r.fill;
  assign ptr_nxt  = (rec_r.ptr[XW-1:0] == XW'(WINDOW - 1)) ? 3'd0 : rec_r.ptr + 3'd1;

  // rank of the entry under idx_r among valid entries, ties broken by position
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      vm[k] = (3'(k) < rec_r.fill) && (win_r[k] >= min_val_r) && (win_r[k] <= max_val_r);
    end
    cnt  = 3'($countones(vm));
    rank = 3'd0;
    for (int j = 0; j < WINDOW; j++) begin
      if (vm[j] && ((win_r[j] < win_r[idx_r]) ||
                    ((win_r[j] == win_r[idx_r]) && (XW'(j) < idx_r)))) begin
        rank = rank + 3'd1;
      end
    end
    lo_rank = (cnt - 3'd1) >> 1;
    hi_rank = cnt >> 1;
    med = (cnt == 3'd0) ? rec_r.median : 16'((17'(lo_r) + 17'(hi_r)) >> 1);
  end

  always_comb begin
    if (state_r == S_EVAL) begin
      mul_a = MUL_A_W'(signed'({rssi_r, 8'h00})) - MUL_A_W'(cur_rec.rssi);
    end else begin
      mul_a = $signed({2'b00, med, 8'h00}) - $signed({2'b00, rec_r.smooth});
    end
    mul_b = $signed({1'b0, w});
  end

  rdft_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign mul_sh     = mul_p >>> 8;
  assign rssi_upd   = 16'(MUL_P_W'(rec_r.rssi) + mul_sh);
  assign smooth_upd = 24'(MUL_P_W'($signed({12'b0, rec_r.smooth})) + mul_sh);

  // slot and window stores
  always_ff @(posedge clk) begin
    rec_rd_r <= slot_mem[slot_r];
    win_rd_r <= win_mem[win_raddr];
    if (state_r == S_WB) begin
      slot_mem[slot_r] <= rec_r;
      if (status_r == ST_ACCEPTED) win_mem[win_waddr] <= dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      rec_vld_r  <= 1'b0;
    end else begin
      rec_vld_r <= slot_vld_r[slot_r];
      if (state_r == S_WB) slot_vld_r[slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_acc_r <= 16'd1500;
      min_val_r <= 16'd10;
      max_val_r <= 16'd2000;
      outl_r    <= 16'd200;
      weight_r  <= 9'd77;
      lr_thr_r  <= 16'd300;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_ACCEPT: max_acc_r <= cfg_data;
        CFG_MIN_VALID:  min_val_r <= cfg_data;
        CFG_MAX_VALID:  max_val_r <= cfg_data;
        CFG_OUTLIER:    outl_r    <= cfg_data;
        CFG_WEIGHT:     weight_r  <= cfg_data[8:0];
        CFG_LONG_RANGE: lr_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser[0];
            slot_r  <= in_slot;
            dist_r  <= in_tdata[19:4];
            rssi_r  <= in_tdata[27:20];
            state_r <= S_SLOT;
          end
        end
        S_SLOT: state_r <= S_EVAL;
        S_EVAL: begin
          if (op_r) begin
            rec_r    <= REC_RESET;
            status_r <= ST_CLEARED;
            state_r  <= S_WB;
          end else if (dist_r > max_acc_r) begin
            rec_r    <= cur_rec;
            status_r <= ST_TOO_FAR;
            state_r  <= S_WB;
          end else begin
            rec_r   <= cur_rec;
            seed_r  <= (cur_rec.rssi < RSSI_SEED_Q8);
            state_r <= S_RSSI;
          end
        end
        S_RSSI: begin
          rec_r.rssi <= seed_r ? {rssi_r, 8'h00} : rssi_upd;
          if (outlier) begin
            status_r <= ST_OUTLIER;
            state_r  <= S_WB;
          end else if (!dist_ok) begin
            status_r <= ST_RANGE;
            state_r  <= S_WB;
          end else begin
            status_r   <= ST_ACCEPTED;
            p_r        <= rec_r.ptr[XW-1:0];
            rec_r.ptr  <= ptr_nxt;
            rec_r.fill <= fill_nxt;
            idx_r      <= '0;
            state_r    <= S_WRD;
          end
        end
        S_WRD: state_r <= S_WCAP;
        S_WCAP: begin
          // the new distance replaces the stale entry at the write slot
          win_r[idx_r] <= (idx_r == p_r) ? dist_r : win_rd_r;
          if (3'(idx_r) == rec_r.fill - 3'd1) begin
            idx_r   <= '0;
            state_r <= S_RANK;
          end else begin
            idx_r   <= idx_r + XW'(1);
            state_r <= S_WRD;
          end
        end
        S_RANK: begin
          if (vm[idx_r] && rank == lo_rank) lo_r <= win_r[idx_r];
          if (vm[idx_r] && rank == hi_rank) hi_r <= win_r[idx_r];
          if (idx_r == XW'(WINDOW - 1)) begin
            state_r <= S_MED;
          end else begin
            idx_r <= idx_r + XW'(1);
          end
        end
        S_MED: begin
          rec_r.median <= med;
          rec_r.lr     <= (med > lr_thr_r);
          seed_r       <= (rec_r.smooth == 24'd0);
          if (rec_r.smooth == 24'd0) rec_r.smooth <= {med, 8'h00};
          state_r <= S_SMOOTH;
        end
        S_SMOOTH: begin
          if (!seed_r) rec_r.smooth <= smooth_upd;
          state_r <= S_WB;
        end
        S_WB: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= status_r;
            out_data_r  <= {7'd0, rec_r.lr, rec_r.rssi[15:8], rec_r.smooth[23:8],
                            rec_r.median};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a beat while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= ST_CLEARED))
    else $error("bad status code");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CLEARED |-> out_tdata[15:0] == 16'd0 && !out_tdata[40])
    else $error("cleared slot not empty");

  a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MED |-> cnt != 3'd0)
    else $error("median taken over empty window");

endmodule

// ===== verif/tb_ranging_distance_filter_table_core.sv =====
// Testbench for ranging_distance_filter_table_core: directed and random range beats,
// predicted per slot in the bench and checked field by field on the result stream.
// Depends on rdft_pkg and the RTL of the core.
module tb_ranging_distance_filter_table_core;
  import rdft_pkg::*;

  localparam int NLINK = 16;
  localparam int WIN = 5;
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 60;

  typedef struct packed {
    logic [2:0] status;
    logic [15:0] median;
    logic [15:0] smoothed;
    logic [7:0] rssi_mean;
    logic far_flag;
  } range_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ranging_distance_filter_table_core dut (.*);

  always #6 clk = ~clk;

  // predictor copy of the registers and slot table
  logic [15:0] lim_accept, lim_min, lim_max, lim_outlier, lim_long;
  logic [8:0] ema_w;
  logic [15:0] win_dist [NLINK][WIN];
  int win_ptr [NLINK];
  int win_fill [NLINK];
  logic [15:0] med_cm [NLINK];
  longint smooth_q8 [NLINK];
  int rssi_q8 [NLINK];
  logic lr_mark [NLINK];

  range_result_t expected_results[$];
  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  function automatic void clear_link(int s);
    for (int i = 0; i < WIN; i++) win_dist[s][i] = '0;
    win_ptr[s] = 0;
    win_fill[s] = 0;
    med_cm[s] = '0;
    smooth_q8[s] = 0;
    rssi_q8[s] = -25600;
    lr_mark[s] = 1'b0;
  endfunction

  function automatic bit dist_valid(logic [15:0] d);
    return d >= lim_min && d <= lim_max;
  endfunction

  function automatic logic [15:0] window_median(int s);
    int v [WIN];
    int n;
    int t;
    int j;
    n = 0;
    for (int i = 0; i < win_fill[s]; i++)
      if (dist_valid(win_dist[s][i])) begin
        v[n] = win_dist[s][i];
        n++;
      end
    if (n == 0) return med_cm[s];
    for (int i = 1; i < n; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    if (n % 2 == 0) return 16'((v[n/2-1] + v[n/2]) >> 1);
    return 16'(v[n/2]);
  endfunction

  function automatic range_result_t filter_step(logic op, logic [3:0] link,
                                                logic [15:0] d, logic signed [7:0] rssi);
    range_result_t r;
    int s;
    int w;
    int diff;
    s = int'(link) % NLINK;
    w = (ema_w > 9'd256) ? 256 : int'(ema_w);
    if (op == OP_CLEAR) begin
      clear_link(s);
      r.status = ST_CLEARED;
    end else if (d > lim_accept) begin
      r.status = ST_TOO_FAR;
    end else begin
      if (rssi_q8[s] < -25344) rssi_q8[s] = int'(rssi) * 256;
      else rssi_q8[s] = (w * int'(rssi) * 256 + (256 - w) * rssi_q8[s]) >>> 8;
      diff = (d > med_cm[s]) ? int'(d) - int'(med_cm[s]) : int'(med_cm[s]) - int'(d);
      if (med_cm[s] != 0 && diff > int'(lim_outlier)) begin
        r.status = ST_OUTLIER;
      end else if (!dist_valid(d)) begin
        r.status = ST_RANGE;
      end else begin
        win_dist[s][win_ptr[s]] = d;
        win_ptr[s] = (win_ptr[s] + 1) % WIN;
        if (win_fill[s] < WIN) win_fill[s]++;
        med_cm[s] = window_median(s);
        if (smooth_q8[s] == 0) smooth_q8[s] = longint'(med_cm[s]) << 8;
        else smooth_q8[s] = (longint'(w) * (longint'(med_cm[s]) << 8) +
                             longint'(256 - w) * smooth_q8[s]) >> 8;
        smooth_q8[s] &= 64'hFFFFFF;
        lr_mark[s] = med_cm[s] > lim_long;
        r.status = ST_ACCEPTED;
      end
    end
    r.median = med_cm[s];
    r.smoothed = 16'(smooth_q8[s] >> 8);
    r.rssi_mean = 8'(rssi_q8[s] >>> 8);
    r.far_flag = lr_mark[s];
    return r;
  endfunction

  // one beat in; valid stays up after acceptance, the caller decides on a gap
  task automatic send_range(logic op, logic [3:0] link, logic [15:0] d,
                            logic signed [7:0] rssi);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {4'b0, rssi, d, link};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(filter_step(op, link, d, rssi));
  endtask

  task automatic sender_gap(int n);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // bursty sender pacing for the random part
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(0, 9));
    end
  endtask

  task automatic drain();
    sender_gap(0);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_ACCEPT: lim_accept = value;
      CFG_MIN_VALID:  lim_min = value;
      CFG_MAX_VALID:  lim_max = value;
      CFG_OUTLIER:    lim_outlier = value;
      CFG_WEIGHT:     ema_w = value[8:0];
      CFG_LONG_RANGE: lim_long = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(logic [15:0] acc, logic [15:0] mn, logic [15:0] mx,
                         logic [15:0] outl, logic [15:0] w, logic [15:0] lr);
    drain();
    write_reg(CFG_MAX_ACCEPT, acc);
    write_reg(CFG_MIN_VALID, mn);
    write_reg(CFG_MAX_VALID, mx);
    write_reg(CFG_OUTLIER, outl);
    write_reg(CFG_WEIGHT, w);
    write_reg(CFG_LONG_RANGE, lr);
  endtask

  task automatic test_directed();
    send_range(OP_CLEAR, 4'd0, 16'hFFFF, -8'sd1);
    send_range(OP_MEASURE, 4'd0, 16'hFFFF, 8'sd0);         // too far
    send_range(OP_MEASURE, 4'd0, 16'd0, -8'sd128);         // seeds rssi, below range
    send_range(OP_MEASURE, 4'd0, 16'd10, -8'sd60);         // min edge
    send_range(OP_MEASURE, 4'd0, 16'd210, -8'sd61);        // jump equals threshold
    send_range(OP_MEASURE, 4'd0, 16'd700, -8'sd62);        // outlier
    send_range(OP_MEASURE, 4'd0, 16'd300, 8'sd0);          // odd count
    send_range(OP_MEASURE, 4'd0, 16'd320, -8'sd40);
    send_range(OP_MEASURE, 4'd0, 16'd330, -8'sd41);
    send_range(OP_MEASURE, 4'd0, 16'd340, -8'sd42);        // window wraps
    send_range(OP_MEASURE, 4'd0, 16'd350, -8'sd43);
    send_range(OP_MEASURE, 4'd15, 16'd1500, -8'sd127);     // accept edge, long range
    send_range(OP_MEASURE, 4'd15, 16'd1501, -8'sd127);
    send_range(OP_MEASURE, 4'd15, 16'd9, -8'sd90);
    send_range(OP_CLEAR, 4'd15, 16'd0, 8'sd0);
    send_range(OP_MEASURE, 4'd15, 16'd5, -8'sd5);
    drain();
    // crossed bounds, saturated weight, open limits
    set_all(16'hFFFF, 16'd500, 16'd400, 16'hFFFF, 16'h01FF, 16'd0);
    send_range(OP_MEASURE, 4'd1, 16'd450, -8'sd70);
    send_range(OP_MEASURE, 4'd0, 16'hFFFF, -8'sd70);
    set_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_range(OP_MEASURE, 4'd2, 16'hFFFF, -8'sd20);
    send_range(OP_MEASURE, 4'd2, 16'hFFFF, -8'sd100);
    send_range(OP_MEASURE, 4'd2, 16'd0, -8'sd3);
  endtask

  task automatic random_phase(int count);
    logic [3:0] link;
    logic [15:0] d;
    int base;
    int span;
    for (int i = 0; i < count; i++) begin
      link = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      base = (med_cm[link] != 0) ? int'(med_cm[link]) : $urandom_range(0, 2500);
      span = (lim_outlier > 16'd400) ? 400 : int'(lim_outlier) + 2;
      case ($urandom_range(0, 9))
        0: d = 16'($urandom);
        1: d = 16'($urandom_range(0, 20));
        2: d = lim_accept + 16'($urandom_range(0, 2));
        default: d = 16'(base - span + int'($urandom_range(0, 2 * span)));
      endcase
      send_range(($urandom_range(0, 14) == 0) ? OP_CLEAR : OP_MEASURE, link, d,
                 8'(-int'($urandom_range(0, 128))));
      pace();
      if (i == count / 2) drain();  // hold off until the pipe is empty
    end
  endtask

  initial begin
    lim_accept = 16'd1500; lim_min = 16'd10; lim_max = 16'd2000;
    lim_outlier = 16'd200; ema_w = 9'd77; lim_long = 16'd300;
    for (int s = 0; s < NLINK; s++) clear_link(s);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    set_all(16'd1500, 16'd10, 16'd2000, 16'd200, 16'd77, 16'd300);
    random_phase(150);
    set_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd1000, 16'd256, 16'd1000);
    random_phase(120);
    set_all(16'd800, 16'd100, 16'd700, 16'd50, 16'd0, 16'd400);
    random_phase(120);
    set_all(16'd3000, 16'd200, 16'd2500, 16'd400, 16'd300, 16'd0);
    random_phase(110);
    drain();
    if (err_count == 0) $display("tb_ranging_distance_filter_table_core: clean");
    else $display("tb_ranging_distance_filter_table_core: errors");
    $finish;
  end

  // receiver stall pattern: free-flowing, random, then long stalls
  always @(negedge clk) begin
    case ((cycle_count / 97) % 3)
      0: out_tready = 1'b1;
      1: out_tready = $urandom_range(0, 1);
      default: out_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    range_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_ranging_distance_filter_table_core: errors");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d got %0d", exp_r.status, out_tuser); err_count++;
        end
        if (out_tdata[15:0] !== exp_r.median) begin
          $error("median: expected %0d got %0d", exp_r.median,
                 out_tdata[15:0]); err_count++;
        end
        if (out_tdata[31:16] !== exp_r.smoothed) begin
          $error("smoothed: expected %0d got %0d", exp_r.smoothed,
                 out_tdata[31:16]); err_count++;
        end
        if (out_tdata[39:32] !== exp_r.rssi_mean) begin
          $error("rssi mean: expected %0d got %0d", $signed(exp_r.rssi_mean),
                 $signed(out_tdata[39:32])); err_count++;
        end
        if (out_tdata[40] !== exp_r.far_flag) begin
          $error("far flag: expected %0d got %0d", exp_r.far_flag, out_tdata[40]);
          err_count++;
        end
      end
    end
  end

endmodule
